>>> hdl/mssc_pkg.sv
// Shared constants, types and helper functions of the seven-segment counter display.
package mssc_pkg;

   // Display geometry
   localparam int NUM_DIGITS = 4;
   localparam int STEP_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_DIGITS - 1);

   // Value and payload widths
   localparam int VAL_W   = 14;
   localparam int SEG_W   = 8;
   localparam int SEL_W   = 8;
   localparam int DIGIT_W = 4;

   // Counter wrap point
   localparam logic [VAL_W-1:0] COUNT_WRAP = VAL_W'(10000);

   // Divide by ten through a reciprocal: exact for every 16-bit value
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 19;
   localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(52429);
   localparam int PROD_W = VAL_W + RECIP_W;
   localparam logic [VAL_W-1:0] DIGIT_RADIX = VAL_W'(10);

   // Configuration registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = VAL_W;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESET_ONE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PRESET_TWO = CSR_IDX_W'(1);
   localparam logic [VAL_W-1:0] PRESET_ONE_RESET = VAL_W'(1234);
   localparam logic [VAL_W-1:0] PRESET_TWO_RESET = VAL_W'(4567);

   // Result queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef logic [VAL_W-1:0] value_type;
   typedef logic [SEG_W-1:0] seg_type;
   typedef logic [NUM_DIGITS-1:0][SEG_W-1:0] seg_vec_type;

   // Active-low common-anode segment code for one decimal digit
   function automatic seg_type seg_of(input logic [DIGIT_W-1:0] digit);
      seg_type code;
      case (digit)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hF8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = 8'hFF;
      endcase
      return code;
   endfunction

   // Active-low digit select: one low bit at the digit position
   function automatic logic [SEL_W-1:0] sel_of(input logic [STEP_W-1:0] idx);
      logic [SEL_W-1:0] sel;
      sel = ~(SEL_W'(1) << idx);
      return sel;
   endfunction

endpackage

>>> hdl/mssc_if.sv
// Handshake channels for refresh requests and digit results.
interface mssc_req_if;
   logic valid;
   logic ready;
   logic key_one_press;
   logic key_two_press;
   logic key_three_press;

   modport source (output valid, key_one_press, key_two_press, key_three_press,
                   input ready);
   modport sink   (input valid, key_one_press, key_two_press, key_three_press,
                   output ready);
endinterface

interface mssc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] segment_pattern;
   logic [7:0] digit_enable;
   logic       last_digit;

   modport source (output valid, segment_pattern, digit_enable, last_digit,
                   input ready);
   modport sink   (input valid, segment_pattern, digit_enable, last_digit,
                   output ready);
endinterface

>>> hdl/multiplexed_seven_segment_counter_unit.sv
// Refresh throughput is set by the digit scan.
// The digit splitter peels one decimal digit per cycle and overlaps the scan of the
// previous value; a two-entry queue decouples key handling from the scan.
// Reset (synchronous, active high): counting mode on, count and shown value zero,
// presets 1234 and 4567, queue and scan empty.
module multiplexed_seven_segment_counter_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [mssc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mssc_pkg::CSR_DATA_W-1:0] csr_write_data,
   mssc_req_if.sink                       req_ch,
   mssc_rsp_if.source                     rsp_ch
);
   import mssc_pkg::*;

   logic      push_valid;
   logic      push_ready;
   value_type push_data;
   logic      pop_valid;
   logic      pop_ready;
   value_type pop_data;

   mssc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   mssc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mssc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> hdl/mssc_fifo.sv
// Short queue of display values between the key front end and the digit back end.
module mssc_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  logic [mssc_pkg::VAL_W-1:0] push_data,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output logic [mssc_pkg::VAL_W-1:0] pop_data
);
   import mssc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   value_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push_fire;
   logic                   pop_fire;

   // Handshake status
   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push_fire  = push_valid & push_ready;
   assign pop_fire   = pop_valid & pop_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/mssc_front.sv
// Front end: preset registers, key handling and the running count.
module mssc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [mssc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mssc_pkg::CSR_DATA_W-1:0] csr_write_data,
   mssc_req_if.sink                       req_ch,
   output logic                           push_valid,
   input  logic                           push_ready,
   output logic [mssc_pkg::VAL_W-1:0]      push_data
);
   import mssc_pkg::*;

   value_type preset_one_ff;
   value_type preset_two_ff;
   value_type running_count_ff, running_count_in;
   value_type shown_value_ff, shown_value_in;
   logic      counting_mode_ff, counting_mode_in;
   value_type count_plus;
   logic      req_fire;

   assign req_ch.ready = push_ready;
   assign req_fire     = req_ch.valid & push_ready;
   assign push_valid   = req_ch.valid;
   assign push_data    = shown_value_in;

   // Apply keys in order, then advance the count in counting mode
   always_comb begin
      running_count_in = running_count_ff;
      shown_value_in   = shown_value_ff;
      counting_mode_in = counting_mode_ff;
      count_plus       = running_count_ff + VAL_W'(1);
      if (req_ch.key_one_press) begin
         shown_value_in   = preset_one_ff;
         counting_mode_in = 1'b0;
      end
      if (req_ch.key_two_press) begin
         shown_value_in   = preset_two_ff;
         counting_mode_in = 1'b0;
      end
      if (req_ch.key_three_press) begin
         counting_mode_in = 1'b1;
      end
      if (counting_mode_in) begin
         shown_value_in   = running_count_ff;
         running_count_in = (count_plus >= COUNT_WRAP) ? '0 : count_plus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_count_ff <= '0;
         shown_value_ff   <= '0;
         counting_mode_ff <= 1'b1;
      end else if (req_fire) begin
         running_count_ff <= running_count_in;
         shown_value_ff   <= shown_value_in;
         counting_mode_ff <= counting_mode_in;
      end
   end

   // Preset register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         preset_one_ff <= PRESET_ONE_RESET;
         preset_two_ff <= PRESET_TWO_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PRESET_ONE: preset_one_ff <= csr_write_data;
            CSR_PRESET_TWO: preset_two_ff <= csr_write_data;
            default:        ;
         endcase
      end
   end

endmodule

>>> hdl/mssc_back.sv
// Back end: splits a value into digits one per cycle and scans them out.
module mssc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  logic [mssc_pkg::VAL_W-1:0] pop_data,
   mssc_rsp_if.source                rsp_ch
);
   import mssc_pkg::*;

   // Converter state
   logic                busy_ff, busy_in;
   logic                full_ff, full_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   value_type           rem_ff, rem_in;
   seg_vec_type         cv_ff, cv_in, cv_next;

   // Scan state
   logic                em_active_ff, em_active_in;
   logic [STEP_W-1:0]   em_idx_ff, em_idx_in;
   seg_vec_type         em_seg_ff, em_seg_in;

   logic [PROD_W-1:0]   prod;
   value_type           quot;
   value_type           ten_quot;
   logic [DIGIT_W-1:0]  digit;
   logic                em_last;
   logic                rsp_fire;
   logic                emit_free;
   logic                at_last;
   logic                take;
   logic                pop_fire;

   // Peel off the lowest digit: quotient by reciprocal, remainder by subtract
   always_comb begin
      prod     = PROD_W'(rem_ff) * PROD_W'(RECIP_TEN);
      quot     = VAL_W'(prod >> RECIP_SHIFT);
      ten_quot = VAL_W'(quot * DIGIT_RADIX);
      digit    = DIGIT_W'(rem_ff - ten_quot);
      cv_next[0] = seg_of(digit);
      for (int j = 1; j < NUM_DIGITS; j++) begin
         cv_next[j] = cv_ff[j-1];
      end
   end

   // Hand-off between converter and scanner
   assign em_last   = (em_idx_ff == LAST_STEP);
   assign rsp_fire  = em_active_ff & rsp_ch.ready;
   assign emit_free = !em_active_ff | (em_last & rsp_ch.ready);
   assign at_last   = busy_ff & (step_ff == LAST_STEP);
   assign take      = emit_free & (at_last | full_ff);
   assign pop_ready = !(busy_ff | full_ff) | take;
   assign pop_fire  = pop_valid & pop_ready;

   // Converter next state
   always_comb begin
      busy_in = busy_ff;
      full_in = full_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      cv_in   = cv_ff;
      if (pop_fire) begin
         busy_in = 1'b1;
         full_in = 1'b0;
         step_in = '0;
         rem_in  = pop_data;
      end else if (take) begin
         busy_in = 1'b0;
         full_in = 1'b0;
      end else if (at_last) begin
         busy_in = 1'b0;
         full_in = 1'b1;
         cv_in   = cv_next;
      end else if (busy_ff) begin
         step_in = step_ff + STEP_W'(1);
         rem_in  = quot;
         cv_in   = cv_next;
      end
   end

   // Scanner next state: load a full digit set, or advance on each transaction
   always_comb begin
      em_active_in = em_active_ff;
      em_idx_in    = em_idx_ff;
      em_seg_in    = em_seg_ff;
      if (take) begin
         em_active_in = 1'b1;
         em_idx_in    = '0;
         em_seg_in    = full_ff ? cv_ff : cv_next;
      end else if (rsp_fire) begin
         if (em_last) begin
            em_active_in = 1'b0;
         end else begin
            em_idx_in = em_idx_ff + STEP_W'(1);
            for (int j = 0; j < NUM_DIGITS - 1; j++) begin
               em_seg_in[j] = em_seg_ff[j+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         full_ff      <= 1'b0;
         step_ff      <= '0;
         em_active_ff <= 1'b0;
         em_idx_ff    <= '0;
      end else begin
         busy_ff      <= busy_in;
         full_ff      <= full_in;
         step_ff      <= step_in;
         em_active_ff <= em_active_in;
         em_idx_ff    <= em_idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      cv_ff     <= cv_in;
      em_seg_ff <= em_seg_in;
   end

   // Drive the result channel
   assign rsp_ch.valid           = em_active_ff;
   assign rsp_ch.segment_pattern = em_seg_ff[0];
   assign rsp_ch.digit_enable    = sel_of(em_idx_ff);
   assign rsp_ch.last_digit      = em_last;

endmodule

>>> hdl/mssc_checker.sv
// Port-level checker for the result channel, bound to the top level.
module mssc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mssc_pkg::SEG_W-1:0]  rsp_segment_pattern,
   input logic [mssc_pkg::SEL_W-1:0]  rsp_digit_enable,
   input logic                        rsp_last_digit
);
   import mssc_pkg::*;

   localparam logic [SEL_W-1:0] LAST_SEL = sel_of(LAST_STEP);

   // Hold a stalled transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segment_pattern)
         && $stable(rsp_digit_enable) && $stable(rsp_last_digit))
      else $error("stalled result changed");

   // Exactly one digit selected
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(~rsp_digit_enable))
      else $error("digit select not one-hot low");

   // Advance the select to the next digit right after a non-final transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_digit |=> rsp_valid
         && (rsp_digit_enable == SEL_W'(($past(rsp_digit_enable) << 1) | SEL_W'(1))))
      else $error("digit scan did not advance");

   // Flag the final digit exactly at the last select
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_digit == (rsp_digit_enable == LAST_SEL)))
      else $error("last digit flag mismatch");

   // Drop results on reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind multiplexed_seven_segment_counter_unit mssc_checker u_mssc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_segment_pattern (rsp_ch.segment_pattern),
   .rsp_digit_enable    (rsp_ch.digit_enable),
   .rsp_last_digit      (rsp_ch.last_digit)
);

>>> verif/tb.sv
// Testbench for the multiplexed seven-segment counter unit: key stimulus, digit checks.
`timescale 1ns / 100ps

module tb;
   import mssc_pkg::*;

   // One digit result as the display scan emits it
   typedef struct packed {
      logic [SEG_W-1:0] segments;
      logic [SEL_W-1:0] select;
      logic             last;
   } digit_result_type;

   // Predicts the digit scan of each refresh and checks the scan against it
   class digit_scoreboard_type;
      value_type        preset_one;
      value_type        preset_two;
      value_type        running_count;
      value_type        shown_value;
      bit               counting_mode;
      logic [7:0]       seg_table [10];
      digit_result_type expected_digits[$];
      int               errors;

      function new();
         preset_one    = PRESET_ONE_RESET;
         preset_two    = PRESET_TWO_RESET;
         running_count = '0;
         shown_value   = '0;
         counting_mode = 1'b1;
         errors        = 0;
         seg_table = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
      endfunction

      function void write_preset(logic [CSR_IDX_W-1:0] index, value_type value);
         if (index == CSR_PRESET_ONE)
            preset_one = value;
         else if (index == CSR_PRESET_TWO)
            preset_two = value;
      endfunction

      function int pending();
         return expected_digits.size();
      endfunction

      // Apply keys in order, advance the count in counting mode, then queue one result per digit
      function void note_refresh(bit key_one, bit key_two, bit key_three);
         digit_result_type d;
         int next_count;
         int place;
         int pos;
         if (key_one) begin
            shown_value   = preset_one;
            counting_mode = 1'b0;
         end
         if (key_two) begin
            shown_value   = preset_two;
            counting_mode = 1'b0;
         end
         if (key_three)
            counting_mode = 1'b1;
         if (counting_mode) begin
            shown_value   = running_count;
            next_count    = int'(running_count) + 1;
            running_count = (next_count >= 10000) ? value_type'(0) : value_type'(next_count);
         end
         for (pos = 0; pos < NUM_DIGITS; pos++) begin
            place      = 10 ** (NUM_DIGITS - 1 - pos);
            d.segments = seg_table[(int'(shown_value) / place) % 10];
            d.select   = ~(SEL_W'(1) << pos);
            d.last     = (pos == NUM_DIGITS - 1);
            expected_digits.push_back(d);
         end
      endfunction

      // Compare one scanned digit with the oldest expected one
      function void check_digit(digit_result_type got);
         digit_result_type want;
         if (expected_digits.size() == 0) begin
            $display("%0t: unexpected digit result: seg %h sel %h last %b", $time,
                     got.segments, got.select, got.last);
            errors++;
            return;
         end
         want = expected_digits.pop_front();
         if (got.segments !== want.segments) begin
            $display("%0t: segment pattern mismatch: expected %h, actual %h", $time,
                     want.segments, got.segments);
            errors++;
         end
         if (got.select !== want.select) begin
            $display("%0t: digit enable mismatch: expected %h, actual %h", $time,
                     want.select, got.select);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last digit flag mismatch: expected %b, actual %b", $time,
                     want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   bit                    idle_on;
   digit_scoreboard_type  sb;

   mssc_req_if req_ch();
   mssc_rsp_if rsp_ch();

   multiplexed_seven_segment_counter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   always #1 clock = ~clock;

   // Write one preset register; starts and ends on a falling edge
   task automatic write_preset(input logic [CSR_IDX_W-1:0] index, input value_type value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      sb.write_preset(index, value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Send one refresh transaction, after a random gap when idling is on; called on a falling edge
   task automatic refresh(input bit key_one, input bit key_two, input bit key_three);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.key_one_press   <= key_one;
      req_ch.key_two_press   <= key_two;
      req_ch.key_three_press <= key_three;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_refresh(key_one, key_two, key_three);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected digit has come out, plus latency
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   function automatic value_type pick_preset();
      case ($urandom_range(0, 4))
         0:       return value_type'(0);
         1:       return value_type'(9999);
         2:       return value_type'(16383);
         default: return value_type'($urandom_range(0, 16383));
      endcase
   endfunction

   // Digit receiver: random stalls when idling is on, check each transaction
   initial begin
      int unsigned stall;
      digit_result_type got;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 6) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         got.segments = rsp_ch.segment_pattern;
         got.select   = rsp_ch.digit_enable;
         got.last     = rsp_ch.last_digit;
         sb.check_digit(got);
         @(negedge clock);
      end
   end

   // Main sequence
   initial begin
      int phase;
      sb                     = new();
      clock                  = 1'b0;
      reset                  = 1'b1;
      idle_on                = 1'b1;
      csr_write_enable       = 1'b0;
      csr_index              = '0;
      csr_write_data         = '0;
      req_ch.valid           = 1'b0;
      req_ch.key_one_press   = 1'b0;
      req_ch.key_two_press   = 1'b0;
      req_ch.key_three_press = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset presets, hold in preset mode, every key combination
      refresh(0, 0, 0);
      refresh(0, 0, 0);
      refresh(1, 0, 0);
      refresh(0, 0, 0);
      refresh(0, 1, 0);
      refresh(0, 0, 0);
      refresh(0, 0, 1);
      refresh(1, 1, 0);
      refresh(1, 0, 1);
      refresh(0, 1, 1);
      refresh(1, 1, 1);
      refresh(0, 0, 0);
      refresh(1, 0, 0);
      refresh(0, 0, 1);

      // Directed: presets above the digit range and at the top of it
      settle();
      write_preset(CSR_PRESET_ONE, value_type'(16383));
      write_preset(CSR_PRESET_TWO, value_type'(9999));
      refresh(1, 0, 0);
      refresh(0, 1, 0);
      refresh(1, 1, 0);
      refresh(0, 0, 1);

      // Directed: zero presets
      settle();
      write_preset(CSR_PRESET_ONE, value_type'(0));
      write_preset(CSR_PRESET_TWO, value_type'(0));
      refresh(1, 0, 0);
      refresh(0, 1, 0);

      // Count at full rate with no idling
      settle();
      idle_on = 1'b0;
      refresh(0, 0, 1);
      repeat (20) refresh(0, 0, 0);

      // Random phases, new presets each, one without idling
      for (phase = 0; phase < 3; phase++) begin
         settle();
         write_preset(CSR_PRESET_ONE, pick_preset());
         write_preset(CSR_PRESET_TWO, pick_preset());
         idle_on = (phase != 1);
         repeat (60)
            refresh($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                    $urandom_range(0, 3) == 0);
      end

      settle();
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
